[rtl/core/dlt_pkg.sv]
`timescale 1ns / 1ps
package dlt_pkg;

    // default sizes
    localparam int DEF_IN_DIM  = 64;
    localparam int DEF_OUT_DIM = 64;
    localparam int DEF_BATCH   = 32;

    // field widths
    localparam int DATA_W = 32;
    localparam int ACC_W  = 48;
    localparam int MAG_W  = 40;
    localparam int CNT_W  = 7;
    localparam int LR_W   = 16;

    // register reset values
    localparam logic [LR_W-1:0]  LEARN_RATE_RST = 16'd66;
    localparam logic [CNT_W-1:0] INPUTS_RST     = 7'd64;
    localparam logic [CNT_W-1:0] OUTPUTS_RST    = 7'd16;

    // register indexes
    localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [1:0] CFG_INPUTS     = 2'd1;
    localparam logic [1:0] CFG_OUTPUTS    = 2'd2;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_FWD    = 2'd1,
        ACT_BWD    = 2'd2,
        ACT_UPDATE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_FWD = 2'd0,
        KIND_UP  = 2'd1,
        KIND_MAG = 2'd2
    } kind_t;

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh0000_7FFF_FFFF_FFFF)
            return 48'sh7FFF_FFFF_FFFF;
        if (v < 64'shFFFF_8000_0000_0000)
            return 48'sh8000_0000_0000;
        return v[ACC_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < 64'shFFFF_FFFF_8000_0000)
            return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] sat40u(input logic [63:0] v);
        if (v > 64'h0000_00FF_FFFF_FFFF)
            return 40'hFF_FFFF_FFFF;
        return v[MAG_W-1:0];
    endfunction

endpackage

[rtl/core/dense_layer_lms_train_unit.sv]
`timescale 1ns / 1ps
// channel   ports                                               transfer at
// --------  --------------------------------------------------  ---------------------
// item in   start, busy, action, row_index, col_index,          start high, busy low
//           sample_slot, value, train
// result    strobe, kind, index, value_res, magnitude, last     every strobe cycle
// config    cfg_we, cfg_index, cfg_data                         cfg_we high
//
// after reset a clearing pass zeroes the gradient and sum memories with busy high. a
// forward element sweeps a weight row, plus the output run on the last element; a
// backward target sweeps a weight column, then a gradient column, plus the upstream
// run on the last target. update visits all IN_DIM*OUT_DIM entries: an in-use entry's
// gradient is divided bit-serially by the sample count, scaled by the learning rate
// and subtracted from its weight, and every gradient is cleared. forward and backward
// passes stream one entry a cycle through a read, multiply, accumulate and
// write-back pipe. results come one per cycle and cannot be held off by the receiver.
module dense_layer_lms_train_unit #(
    parameter int IN_DIM  = dlt_pkg::DEF_IN_DIM,
    parameter int OUT_DIM = dlt_pkg::DEF_OUT_DIM,
    parameter int BATCH   = dlt_pkg::DEF_BATCH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        action,
    input  logic [5:0]                        row_index,
    input  logic [5:0]                        col_index,
    input  logic [4:0]                        sample_slot,
    input  logic signed [dlt_pkg::DATA_W-1:0] value,
    input  logic                              train,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [dlt_pkg::LR_W-1:0]          cfg_data,
    output logic                              strobe,
    output logic [1:0]                        kind,
    output logic [5:0]                        index,
    output logic signed [dlt_pkg::DATA_W-1:0] value_res,
    output logic [dlt_pkg::MAG_W-1:0]         magnitude,
    output logic                              last
);
    import dlt_pkg::*;

    localparam int IW  = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int OW  = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
    localparam int WD  = IN_DIM * OUT_DIM;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
    localparam int CD  = BATCH * IN_DIM;
    localparam int CAW = (CD > 1) ? $clog2(CD) : 1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD,
        ST_FEMIT,
        ST_BWD1,
        ST_DIFF,
        ST_BWD2,
        ST_BEMIT,
        ST_URD,
        ST_UWAIT,
        ST_UDIV,
        ST_UMUL,
        ST_UWR,
        ST_UOUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [LR_W-1:0]  learn_rate_reg;
    logic [CNT_W-1:0] inputs_in_use_reg;
    logic [CNT_W-1:0] outputs_in_use_reg;

    // control
    logic [CNT_W-1:0] iss_cnt_reg;
    logic             p1_v_reg;
    logic             p2_v_reg;
    logic [CNT_W-1:0] p1_idx_reg;
    logic [CNT_W-1:0] p2_idx_reg;
    logic [CNT_W-1:0] trained_reg;
    logic [WAW-1:0]   clr_cnt_reg;
    logic [WAW-1:0]   k_reg;
    logic [IW-1:0]    ui_reg;
    logic [OW-1:0]    uj_reg;
    logic [5:0]       div_cnt_reg;

    // datapath
    logic signed [DATA_W-1:0] val_reg;
    logic [5:0]               row_reg;
    logic [5:0]               col_reg;
    logic [4:0]               slot_reg;
    logic signed [63:0]       prod0_reg;
    logic signed [63:0]       prod1_reg;
    logic signed [ACC_W-1:0]  acc_q_reg;
    logic signed [ACC_W-1:0]  pred_reg;
    logic signed [DATA_W-1:0] diff_reg;
    logic                     g_neg_reg;
    logic [ACC_W-1:0]         div_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic signed [DATA_W-1:0] w_q_reg;
    logic signed [63:0]       uprod_reg;
    logic [MAG_W-1:0]         mag_reg;

    // outputs
    logic                     strobe_reg;
    kind_t                    kind_reg;
    logic [5:0]               index_reg;
    logic signed [DATA_W-1:0] value_res_reg;
    logic [MAG_W-1:0]         magnitude_reg;
    logic                     last_reg;

    // memory ports
    logic                     w_we;
    logic [WAW-1:0]           w_waddr;
    logic [DATA_W-1:0]        w_wdata;
    logic [WAW-1:0]           w_raddr;
    logic signed [DATA_W-1:0] w_rdata;
    logic                     g_we;
    logic [WAW-1:0]           g_waddr;
    logic [ACC_W-1:0]         g_wdata;
    logic [WAW-1:0]           g_raddr;
    logic signed [ACC_W-1:0]  g_rdata;
    logic                     c_we;
    logic [CAW-1:0]           c_waddr;
    logic [CAW-1:0]           c_raddr;
    logic signed [DATA_W-1:0] c_rdata;
    logic                     f_we;
    logic [OW-1:0]            f_waddr;
    logic [ACC_W-1:0]         f_wdata;
    logic signed [ACC_W-1:0]  f_rdata;
    logic                     u_we;
    logic [IW-1:0]            u_waddr;
    logic [ACC_W-1:0]         u_wdata;
    logic signed [ACC_W-1:0]  u_rdata;

    // combinational helpers
    logic [CNT_W-1:0]         n_in;
    logic [CNT_W-1:0]         n_out;
    logic [CNT_W-1:0]         sweep_n;
    logic                     sweeping;
    logic                     issuing;
    logic                     drained;
    logic                     accept;
    logic                     in_use;
    logic                     upd_end;
    logic [CNT_W-1:0]         count;
    logic [CNT_W:0]           rem_shift;
    logic                     rem_ge;
    logic signed [63:0]       mul0;
    logic signed [63:0]       mul1;
    logic signed [DATA_W-1:0] mul1_b;
    logic signed [ACC_W-1:0]  s2_sum;
    logic signed [ACC_W-1:0]  pred_sum;
    logic signed [DATA_W-1:0] diff_val;
    logic signed [48:0]       q_s;
    logic signed [16:0]       lr_s;
    logic signed [65:0]       uprod_full;
    logic signed [DATA_W-1:0] new_w;
    logic [ACC_W-1:0]         g_abs;
    logic [MAG_W-1:0]         mag_sum;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    assign n_in  = (inputs_in_use_reg == '0) ? CNT_W'(1) :
                   (inputs_in_use_reg > CNT_W'(IN_DIM)) ? CNT_W'(IN_DIM) : inputs_in_use_reg;
    assign n_out = (outputs_in_use_reg == '0) ? CNT_W'(1) :
                   (outputs_in_use_reg > CNT_W'(OUT_DIM)) ? CNT_W'(OUT_DIM) : outputs_in_use_reg;

    // streaming passes over a weight row or column
    assign sweep_n  = (state_reg == ST_FWD || state_reg == ST_FEMIT) ? n_out : n_in;
    assign sweeping = (state_reg == ST_FWD) || (state_reg == ST_FEMIT) ||
                      (state_reg == ST_BWD1) || (state_reg == ST_BWD2) ||
                      (state_reg == ST_BEMIT);
    assign issuing  = sweeping && (iss_cnt_reg < sweep_n);
    assign drained  = (iss_cnt_reg == sweep_n) && !p1_v_reg && !p2_v_reg;

    // multipliers, one register stage after each
    assign mul1_b = (state_reg == ST_BWD2) ? diff_reg : w_rdata;
    assign mul0   = val_reg * w_rdata;
    assign mul1   = c_rdata * mul1_b;

    // accumulate with floor shift of the product
    assign s2_sum   = sat48(64'(acc_q_reg) +
                            (((state_reg == ST_BWD2) ? prod1_reg : prod0_reg) >>> 16));
    assign pred_sum = sat48(64'(pred_reg) + (prod1_reg >>> 16));
    assign diff_val = sat32(64'(sat32(64'(pred_reg))) - 64'(val_reg));

    // update helpers
    assign in_use    = (CNT_W'(ui_reg) < n_in) && (CNT_W'(uj_reg) < n_out);
    assign upd_end   = (k_reg == WAW'(WD - 1));
    assign count     = (trained_reg == '0) ? CNT_W'(1) : trained_reg;
    assign rem_shift = {rem_reg, div_reg[ACC_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, count});
    assign q_s       = g_neg_reg ? -$signed({1'b0, div_reg}) : $signed({1'b0, div_reg});
    assign lr_s      = $signed({1'b0, learn_rate_reg});
    assign uprod_full = q_s * lr_s;
    assign new_w     = sat32(64'(w_q_reg) - (uprod_reg >>> 16));
    assign g_abs     = g_rdata[ACC_W-1] ? ACC_W'(-g_rdata) : g_rdata;
    assign mag_sum   = sat40u(64'(mag_reg) + 64'(div_reg));

    // weight memory
    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = WAW'(row_index) * WAW'(OUT_DIM) + WAW'(col_index);
        w_wdata = value;
        if (state_reg == ST_UWR)
        begin
            w_we    = 1'b1;
            w_waddr = k_reg;
            w_wdata = new_w;
        end
        else if (accept && action == ACT_LOAD &&
                 7'(row_index) < 7'(IN_DIM) && 7'(col_index) < 7'(OUT_DIM))
        begin
            w_we = 1'b1;
        end
        unique case (state_reg)
            ST_FWD:  w_raddr = WAW'(row_reg) * WAW'(OUT_DIM) + WAW'(iss_cnt_reg[OW-1:0]);
            ST_BWD1: w_raddr = WAW'(iss_cnt_reg[IW-1:0]) * WAW'(OUT_DIM) + WAW'(col_reg);
            default: w_raddr = k_reg;
        endcase
    end

    // gradient memory
    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = k_reg;
        g_wdata = '0;
        g_raddr = k_reg;
        if (state_reg == ST_CLEAR)
        begin
            g_we    = 1'b1;
            g_waddr = clr_cnt_reg;
        end
        else if (state_reg == ST_BWD2)
        begin
            g_we    = p2_v_reg;
            g_waddr = WAW'(p2_idx_reg[IW-1:0]) * WAW'(OUT_DIM) + WAW'(col_reg);
            g_wdata = s2_sum;
            g_raddr = WAW'(iss_cnt_reg[IW-1:0]) * WAW'(OUT_DIM) + WAW'(col_reg);
        end
        else if ((state_reg == ST_URD && !in_use) || state_reg == ST_UWR)
        begin
            g_we = 1'b1;
        end
    end

    // sample cache, sum memories
    always_comb
    begin
        c_we    = accept && action == ACT_FWD && 7'(row_index) < n_in && train &&
                  7'(sample_slot) < 7'(BATCH);
        c_waddr = CAW'(sample_slot) * CAW'(IN_DIM) + CAW'(row_index);
        c_raddr = CAW'(slot_reg) * CAW'(IN_DIM) + CAW'(iss_cnt_reg[IW-1:0]);

        f_we    = 1'b0;
        f_waddr = p2_idx_reg[OW-1:0];
        f_wdata = '0;
        u_we    = 1'b0;
        u_waddr = p2_idx_reg[IW-1:0];
        u_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                f_we    = int'(clr_cnt_reg) < OUT_DIM;
                f_waddr = clr_cnt_reg[OW-1:0];
                u_we    = int'(clr_cnt_reg) < IN_DIM;
                u_waddr = clr_cnt_reg[IW-1:0];
            end
            ST_FWD:
            begin
                f_we    = p2_v_reg;
                f_wdata = s2_sum;
            end
            ST_FEMIT:
            begin
                f_we    = p1_v_reg;
                f_waddr = p1_idx_reg[OW-1:0];
            end
            ST_BWD1:
            begin
                u_we    = p2_v_reg;
                u_wdata = s2_sum;
            end
            ST_BEMIT:
            begin
                u_we    = p1_v_reg;
                u_waddr = p1_idx_reg[IW-1:0];
            end
            default:
            begin
                f_we = 1'b0;
            end
        endcase
    end

    dlt_ram #(.WIDTH(DATA_W), .DEPTH(WD)) u_weight (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dlt_ram #(.WIDTH(ACC_W), .DEPTH(WD)) u_grad (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    dlt_ram #(.WIDTH(DATA_W), .DEPTH(CD)) u_cache (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (value),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    dlt_ram #(.WIDTH(ACC_W), .DEPTH(OUT_DIM)) u_fsum (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (iss_cnt_reg[OW-1:0]),
        .rdata (f_rdata)
    );

    dlt_ram #(.WIDTH(ACC_W), .DEPTH(IN_DIM)) u_usum (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (iss_cnt_reg[IW-1:0]),
        .rdata (u_rdata)
    );

    // state, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            learn_rate_reg     <= LEARN_RATE_RST;
            inputs_in_use_reg  <= INPUTS_RST;
            outputs_in_use_reg <= OUTPUTS_RST;
            iss_cnt_reg        <= '0;
            p1_v_reg           <= 1'b0;
            p2_v_reg           <= 1'b0;
            p1_idx_reg         <= '0;
            p2_idx_reg         <= '0;
            trained_reg        <= '0;
            clr_cnt_reg        <= '0;
            k_reg              <= '0;
            ui_reg             <= '0;
            uj_reg             <= '0;
            div_cnt_reg        <= '0;
            strobe_reg         <= 1'b0;
            kind_reg           <= KIND_FWD;
            index_reg          <= '0;
            value_res_reg      <= '0;
            magnitude_reg      <= '0;
            last_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LEARN_RATE: learn_rate_reg     <= cfg_data;
                    CFG_INPUTS:     inputs_in_use_reg  <= cfg_data[CNT_W-1:0];
                    CFG_OUTPUTS:    outputs_in_use_reg <= cfg_data[CNT_W-1:0];
                    default:        learn_rate_reg     <= learn_rate_reg;
                endcase
            end

            // pass pipe: issue, read data, write back
            p1_v_reg   <= issuing;
            p1_idx_reg <= iss_cnt_reg;
            p2_v_reg   <= p1_v_reg;
            p2_idx_reg <= p1_idx_reg;
            if (issuing)
            begin
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            end

            strobe_reg <= 1'b0;

            unique case (state_reg) inside
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + WAW'(1);
                    if (clr_cnt_reg == WAW'(WD - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    iss_cnt_reg <= '0;
                    if (accept)
                    begin
                        unique case (action)
                            ACT_FWD:
                            begin
                                if (7'(row_index) < n_in)
                                begin
                                    state_reg <= ST_FWD;
                                end
                            end
                            ACT_BWD:
                            begin
                                if (7'(col_index) < n_out && 7'(sample_slot) < 7'(BATCH))
                                begin
                                    state_reg <= ST_BWD1;
                                end
                            end
                            ACT_UPDATE:
                            begin
                                k_reg     <= '0;
                                ui_reg    <= '0;
                                uj_reg    <= '0;
                                state_reg <= ST_URD;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_FWD:
                begin
                    if (drained)
                    begin
                        iss_cnt_reg <= '0;
                        state_reg   <= (7'(row_reg) == n_in - 7'd1) ? ST_FEMIT : ST_IDLE;
                    end
                end
                ST_FEMIT, ST_BEMIT:
                begin
                    if (p1_v_reg)
                    begin
                        strobe_reg    <= 1'b1;
                        kind_reg      <= (state_reg == ST_FEMIT) ? KIND_FWD : KIND_UP;
                        index_reg     <= 6'(p1_idx_reg);
                        value_res_reg <= sat32(64'((state_reg == ST_FEMIT) ? f_rdata : u_rdata));
                        magnitude_reg <= '0;
                        last_reg      <= (p1_idx_reg == sweep_n - 7'd1);
                    end
                    if (drained)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_BWD1:
                begin
                    if (drained)
                    begin
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    iss_cnt_reg <= '0;
                    state_reg   <= ST_BWD2;
                end
                ST_BWD2:
                begin
                    if (drained)
                    begin
                        iss_cnt_reg <= '0;
                        if (7'(col_reg) == n_out - 7'd1)
                        begin
                            if (trained_reg != 7'd127)
                            begin
                                trained_reg <= trained_reg + 7'd1;
                            end
                            state_reg <= ST_BEMIT;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_URD, ST_UWR:
                begin
                    if (state_reg == ST_URD && in_use)
                    begin
                        state_reg <= ST_UWAIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + WAW'(1);
                        if (uj_reg == OW'(OUT_DIM - 1))
                        begin
                            uj_reg <= '0;
                            ui_reg <= ui_reg + IW'(1);
                        end
                        else
                        begin
                            uj_reg <= uj_reg + OW'(1);
                        end
                        state_reg <= upd_end ? ST_UOUT : ST_URD;
                    end
                end
                ST_UWAIT:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= ST_UDIV;
                end
                ST_UDIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'(ACC_W - 1))
                    begin
                        state_reg <= ST_UMUL;
                    end
                end
                ST_UMUL:
                begin
                    state_reg <= ST_UWR;
                end
                ST_UOUT:
                begin
                    strobe_reg    <= 1'b1;
                    kind_reg      <= KIND_MAG;
                    index_reg     <= '0;
                    value_res_reg <= '0;
                    magnitude_reg <= mag_reg;
                    last_reg      <= 1'b1;
                    trained_reg   <= '0;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg  <= value;
            row_reg  <= row_index;
            col_reg  <= col_index;
            slot_reg <= sample_slot;
            pred_reg <= '0;
            mag_reg  <= '0;
        end

        // read data stage
        prod0_reg <= mul0;
        prod1_reg <= mul1;
        case (state_reg)
            ST_FWD:  acc_q_reg <= f_rdata;
            ST_BWD1: acc_q_reg <= u_rdata;
            default: acc_q_reg <= g_rdata;
        endcase

        if (state_reg == ST_BWD1 && p2_v_reg)
        begin
            pred_reg <= pred_sum;
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= diff_val;
        end

        // bit-serial divide of the gradient magnitude by the sample count
        if (state_reg == ST_UWAIT)
        begin
            g_neg_reg <= g_rdata[ACC_W-1];
            div_reg   <= g_abs;
            rem_reg   <= '0;
            w_q_reg   <= w_rdata;
        end
        else if (state_reg == ST_UDIV)
        begin
            rem_reg <= rem_ge ? CNT_W'(rem_shift - {1'b0, count}) : rem_shift[CNT_W-1:0];
            div_reg <= {div_reg[ACC_W-2:0], rem_ge};
        end
        if (state_reg == ST_UMUL)
        begin
            uprod_reg <= uprod_full[63:0];
            mag_reg   <= mag_sum;
        end
    end

    assign strobe    = strobe_reg;
    assign kind      = kind_reg;
    assign index     = index_reg;
    assign value_res = value_res_reg;
    assign magnitude = magnitude_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    // the pass pipe is empty whenever a new item may be taken
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (!p1_v_reg && !p2_v_reg))
        else $error("pass pipe not empty while idle");

    // a run ends before the next one can start
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("result right after the last of a run");

    // results only come out of work in progress
    a_strobe_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result without work");
`endif

endmodule

[rtl/core/dlt_ram.sv]
`timescale 1ns / 1ps
module dlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
